// File: hw/rtl/tset_pkg.sv
// Package for the time-sorted event table: sizes, codes and shared types.
// No dependencies. Used by the cell and the top level.
`default_nettype none

package tset_pkg;

  // table size and stored tag width
  localparam int CAPACITY = 16;
  localparam int TAG_BITS = 64;

  localparam int IDX_W = $clog2(CAPACITY);
  localparam int CNT_W = $clog2(CAPACITY + 1);
  // width wide enough for both the count and the 4-bit slot index
  localparam int CMP_W = (CNT_W > 5) ? CNT_W : 5;

  // command codes
  typedef enum logic [1:0] {
    CMD_INSERT = 2'd0,
    CMD_DELETE = 2'd1,
    CMD_READ   = 2'd2,
    CMD_NOP    = 2'd3
  } tset_cmd_t;

  // result status codes
  typedef enum logic [1:0] {
    ST_OK     = 2'd0,
    ST_FULL   = 2'd1,
    ST_BADIDX = 2'd2
  } tset_status_t;

  // one stored entry
  typedef struct packed {
    logic [4:0]          hour;
    logic [5:0]          minute;
    logic [TAG_BITS-1:0] tag;
  } tset_entry_t;

  // broadcast from the controller to every cell
  typedef struct packed {
    logic              ins;      // insert takes effect this cycle
    logic              del;      // delete takes effect this cycle
    logic [IDX_W-1:0]  del_idx;  // slot being removed
    tset_entry_t       new_ent;  // entry being inserted
  } tset_bcast_t;

endpackage

`default_nettype wire

// File: hw/rtl/tset_in_if.sv
// Command channel of the time-sorted event table: valid/ready plus payload.
// No dependencies.
`default_nettype none

interface tset_in_if;
  logic        valid;
  logic        ready;
  logic [1:0]  cmd;
  logic [4:0]  event_hour;
  logic [5:0]  event_minute;
  logic [63:0] event_tag;
  logic [3:0]  slot_index;

  modport source (output valid, cmd, event_hour, event_minute, event_tag, slot_index,
                  input ready);
  modport sink   (input valid, cmd, event_hour, event_minute, event_tag, slot_index,
                  output ready);
endinterface

`default_nettype wire

// File: hw/rtl/tset_out_if.sv
// Result channel of the time-sorted event table: valid/ready plus payload.
// No dependencies.
`default_nettype none

interface tset_out_if;
  logic        valid;
  logic        ready;
  logic [1:0]  status;
  logic [3:0]  position;
  logic [4:0]  out_hour;
  logic [5:0]  out_minute;
  logic [63:0] out_tag;
  logic [4:0]  occupancy;

  modport source (output valid, status, position, out_hour, out_minute, out_tag,
                  occupancy, input ready);
  modport sink   (input valid, status, position, out_hour, out_minute, out_tag,
                  occupancy, output ready);
endinterface

`default_nettype wire

// File: hw/rtl/tset_cell.sv
// One slot of the sorted table: holds an entry, compares it with the
// incoming key and shifts to or from its neighbours. Depends on tset_pkg.
`default_nettype none

module tset_cell
  import tset_pkg::*;
(
  input  wire logic             clk,
  input  wire tset_bcast_t      bc,
  input  wire logic [IDX_W-1:0] cell_idx,
  input  wire logic             occupied,
  input  wire logic             left_le,
  input  wire tset_entry_t      left_entry,
  input  wire tset_entry_t      right_entry,
  output tset_entry_t           entry,
  output logic                  le
);

  tset_entry_t entry_r;
  tset_entry_t entry_nxt;

  // key is hour*100+minute; minute stays below 100, so {hour,minute} orders the same
  assign le = occupied &&
              ({entry_r.hour, entry_r.minute} <= {bc.new_ent.hour, bc.new_ent.minute});

  // keep, take the new entry, or shift from a neighbour
  always_comb begin
    entry_nxt = entry_r;
    if (bc.ins) begin
      if (!le) begin
        entry_nxt = left_le ? bc.new_ent : left_entry;
      end
    end else if (bc.del) begin
      if (cell_idx >= bc.del_idx) begin
        entry_nxt = right_entry;
      end
    end
  end

  always_ff @(posedge clk) begin
    entry_r <= entry_nxt;
  end

  assign entry = entry_r;

endmodule

`default_nettype wire

// File: hw/rtl/time_sorted_event_table.sv
// Time-sorted event table: up to CAPACITY entries (hour, minute, tag) kept in
// ascending time order in a row of cells; insert is stable, delete closes the
// gap, read returns one slot. All cells compare and shift together in the
// cycle the transaction is accepted, and the result sits in one output
// register, so a new command is taken in every cycle while the result side
// keeps up. Depends on tset_pkg, tset_in_if, tset_out_if and tset_cell.
`default_nettype none

module time_sorted_event_table
  import tset_pkg::*;
(
  input wire logic  clk,
  input wire logic  rst_n,
  tset_in_if.sink   in_ch,
  tset_out_if.source out_ch
);

  logic [CNT_W-1:0] count_r, count_nxt;
  logic             out_valid_r;
  logic [1:0]       status_r, status_nxt;
  logic [3:0]       position_r, position_nxt;
  logic [4:0]       hour_r, hour_nxt;
  logic [5:0]       minute_r, minute_nxt;
  logic [63:0]      tag_r, tag_nxt;

  logic             in_acc;
  logic             full;
  logic             idx_ok;
  logic [IDX_W-1:0] sel_idx;
  logic [IDX_W-1:0] ins_pos;
  tset_cmd_t        cmd;
  tset_bcast_t      bc;
  tset_entry_t      sel_entry;

  tset_entry_t      cell_entry [CAPACITY];
  logic [CAPACITY-1:0] cell_le;

  // handshake: output register frees as it is taken
  assign in_ch.ready = !out_valid_r || out_ch.ready;
  assign in_acc      = in_ch.valid && in_ch.ready;

  assign cmd     = tset_cmd_t'(in_ch.cmd);
  assign full    = (count_r == CNT_W'(CAPACITY));
  assign idx_ok  = (CMP_W'(in_ch.slot_index) < CMP_W'(count_r)) &&
                   (CMP_W'(in_ch.slot_index) < CMP_W'(CAPACITY));
  assign sel_idx = IDX_W'(in_ch.slot_index);

  // broadcast to the cells
  always_comb begin
    bc.ins            = in_acc && (cmd == CMD_INSERT) && !full;
    bc.del            = in_acc && (cmd == CMD_DELETE) && idx_ok;
    bc.del_idx        = sel_idx;
    bc.new_ent.hour   = in_ch.event_hour;
    bc.new_ent.minute = in_ch.event_minute;
    bc.new_ent.tag    = in_ch.event_tag[TAG_BITS-1:0];
  end

  // row of cells
  for (genvar i = 0; i < CAPACITY; i++) begin : g_cell
    logic        occ;
    logic        lft_le;
    tset_entry_t lft_ent;
    tset_entry_t rgt_ent;

    assign occ = (CNT_W'(i) < count_r);
    if (i == 0) begin : g_first
      assign lft_le  = 1'b1;
      assign lft_ent = bc.new_ent;
    end else begin : g_mid
      assign lft_le  = cell_le[i-1];
      assign lft_ent = cell_entry[i-1];
    end
    if (i == CAPACITY - 1) begin : g_last
      assign rgt_ent = cell_entry[i];
    end else begin : g_notlast
      assign rgt_ent = cell_entry[i+1];
    end

    tset_cell u_cell (
      .clk        (clk),
      .bc         (bc),
      .cell_idx   (IDX_W'(i)),
      .occupied   (occ),
      .left_le    (lft_le),
      .left_entry (lft_ent),
      .right_entry(rgt_ent),
      .entry      (cell_entry[i]),
      .le         (cell_le[i])
    );
  end

  // insert position: the one cell where the le flags drop
  always_comb begin
    ins_pos = '0;
    for (int i = 0; i < CAPACITY; i++) begin
      if (!cell_le[i] && ((i == 0) || cell_le[(i == 0) ? 0 : i - 1])) begin
        ins_pos = ins_pos | IDX_W'(i);
      end
    end
  end

  assign sel_entry = cell_entry[sel_idx];

  // result and next count
  always_comb begin
    status_nxt   = ST_OK;
    position_nxt = '0;
    hour_nxt     = '0;
    minute_nxt   = '0;
    tag_nxt      = '0;
    count_nxt    = count_r;
    case (cmd)
      CMD_INSERT: begin
        if (full) begin
          status_nxt = ST_FULL;
        end else begin
          position_nxt = 4'(ins_pos);
          count_nxt    = count_r + 1'b1;
        end
      end
      CMD_DELETE, CMD_READ: begin
        position_nxt = in_ch.slot_index;
        if (!idx_ok) begin
          status_nxt = ST_BADIDX;
        end else begin
          hour_nxt   = sel_entry.hour;
          minute_nxt = sel_entry.minute;
          tag_nxt    = 64'(sel_entry.tag);
          if (cmd == CMD_DELETE) begin
            count_nxt = count_r - 1'b1;
          end
        end
      end
      default: begin
      end
    endcase
  end

  // control state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      count_r     <= '0;
      out_valid_r <= 1'b0;
    end else begin
      if (in_acc) begin
        count_r     <= count_nxt;
        out_valid_r <= 1'b1;
      end else if (out_ch.ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  // result payload
  always_ff @(posedge clk) begin
    if (in_acc) begin
      status_r   <= status_nxt;
      position_r <= position_nxt;
      hour_r     <= hour_nxt;
      minute_r   <= minute_nxt;
      tag_r      <= tag_nxt;
    end
  end

  assign out_ch.valid      = out_valid_r;
  assign out_ch.status     = status_r;
  assign out_ch.position   = position_r;
  assign out_ch.out_hour   = hour_r;
  assign out_ch.out_minute = minute_r;
  assign out_ch.out_tag    = tag_r;
  assign out_ch.occupancy  = 5'(count_r);

  // checks
  a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
    count_r <= CNT_W'(CAPACITY))
    else $error("entry count above capacity");

  a_ins_count: assert property (@(posedge clk) disable iff (!rst_n)
    (rst_n && bc.ins) |=> (count_r == $past(count_r) + 1'b1))
    else $error("insert did not grow the table");

  a_full_status: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && (status_r == ST_FULL)) |-> (count_r == CNT_W'(CAPACITY)))
    else $error("full status with free slots");

  a_stall_cause: assert property (@(posedge clk) disable iff (!rst_n)
    !in_ch.ready |-> out_valid_r)
    else $error("input stalled with empty output register");

endmodule

`default_nettype wire
